>>> rtl/core/bct_pkg.sv
// package of shared types and constants for the blob centroid tracker
`default_nettype none
package bct_pkg;

    localparam int unsigned MAX_TRACKS_DEF   = 64;
    localparam logic [15:0] RADIUS_RESET     = 16'd160;
    localparam int unsigned COORD_W          = 16;
    localparam int unsigned LABEL_W          = 8;
    localparam int unsigned DIST_W           = 2 * COORD_W + 1;

    typedef struct packed {
        logic [COORD_W-1:0] blob_x;
        logic [COORD_W-1:0] blob_y;
        logic               first_in_frame;
        logic               last_in_frame;
    } bct_in_t;

    typedef struct packed {
        logic [LABEL_W-1:0] track_label;
        logic               new_track;
        logic               table_full;
    } bct_out_t;

    // one track table entry as held in memory
    typedef struct packed {
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [LABEL_W-1:0] id;
    } bct_entry_t;

    // slot index and label travelling with a distance calculation
    typedef struct packed {
        logic               vld;
        logic [7:0]         idx;
        logic [LABEL_W-1:0] id;
    } bct_tag_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_THR   = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_FIN   = 5'b01000,
        ST_CLEAN = 5'b10000
    } bct_state_t;

endpackage
`default_nettype wire

>>> rtl/core/bct_ram.sv
// generic simple dual port ram with registered read
`default_nettype none
module bct_ram #(
    parameter int unsigned WIDTH = 40,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> rtl/core/bct_dist.sv
// two stage squared distance pipeline between a blob and a stored track
`default_nettype none
module bct_dist (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire bct_pkg::bct_tag_t             in_tag,
    input  wire logic [bct_pkg::COORD_W-1:0]   bx,
    input  wire logic [bct_pkg::COORD_W-1:0]   by,
    input  wire logic [bct_pkg::COORD_W-1:0]   tx,
    input  wire logic [bct_pkg::COORD_W-1:0]   ty,
    output bct_pkg::bct_tag_t                  out_tag,
    output logic [bct_pkg::DIST_W-1:0]         sq_dist,
    output logic                               busy
);

    bct_pkg::bct_tag_t                  a_tag_reg, b_tag_reg;
    logic [bct_pkg::COORD_W-1:0]        dx_reg, dy_reg;
    logic [2*bct_pkg::COORD_W-1:0]      sqx_reg, sqy_reg;

    // absolute differences, then their squares
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_tag_reg.vld <= 1'b0;
            b_tag_reg.vld <= 1'b0;
        end else begin
            a_tag_reg.vld <= in_tag.vld;
            b_tag_reg.vld <= a_tag_reg.vld;
        end
        a_tag_reg.idx <= in_tag.idx;
        a_tag_reg.id  <= in_tag.id;
        b_tag_reg.idx <= a_tag_reg.idx;
        b_tag_reg.id  <= a_tag_reg.id;
        dx_reg  <= (bx >= tx) ? (bx - tx) : (tx - bx);
        dy_reg  <= (by >= ty) ? (by - ty) : (ty - by);
        sqx_reg <= dx_reg * dx_reg;
        sqy_reg <= dy_reg * dy_reg;
    end

    assign out_tag = b_tag_reg;
    assign sq_dist = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign busy    = a_tag_reg.vld | b_tag_reg.vld;

endmodule
`default_nettype wire

>>> rtl/core/blob_centroid_tracker.sv
// top level of the nearest neighbour blob centroid tracker
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------
//  s_      | in        | s_valid / s_ready  | s_data : blob request
//  m_      | out       | m_valid / m_ready  | m_data : label result
//  cfg_    | in        | cfg_we, no wait    | cfg_wdata : match radius
//
// one request at a time: accept, threshold, a scan of every stored track
// with the distance pipeline drained after it, the result, and on the
// last blob of a frame a compaction pass; the scan and the compaction
// are paced by the single read port of the track memory. an empty frame
// request goes from accept straight to the result.
// reset clears counts, seen marks and label usage at once; memory contents
// need no clearing since only slots below the count are read.
// the result sits in an output register, so a new request is taken while
// the previous result waits for m_ready.
`default_nettype none
module blob_centroid_tracker #(
    parameter int unsigned MAX_TRACKS = bct_pkg::MAX_TRACKS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire bct_pkg::bct_in_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output bct_pkg::bct_out_t      m_data,
    input  wire logic              cfg_we,
    input  wire logic [15:0]       cfg_wdata
);

    localparam int unsigned CW = $clog2(MAX_TRACKS + 1);   // count width
    localparam int unsigned IW = $clog2(MAX_TRACKS);       // slot index width
    localparam int unsigned LW = $clog2(MAX_TRACKS + 1);   // label index width
    localparam int unsigned EW = $bits(bct_pkg::bct_entry_t);

    bct_pkg::bct_state_t                state_reg, state_next;
    logic [15:0]                        radius_reg, radius_next;
    logic [31:0]                        thresh_reg, thresh_next;
    logic [CW-1:0]                      cnt_reg, cnt_next;
    logic [MAX_TRACKS-1:0]              seen_reg, seen_next;
    logic [MAX_TRACKS:0]                used_reg, used_next;
    bct_pkg::bct_in_t                   blob_reg, blob_next;
    logic                               empty_reg, empty_next;
    logic [CW-1:0]                      iss_reg, iss_next;
    logic                               iss_done_reg, iss_done_next;
    bct_pkg::bct_tag_t                  p1_reg, p1_next;
    logic                               found_reg, found_next;
    logic [bct_pkg::DIST_W-1:0]         best_d_reg, best_d_next;
    logic [IW-1:0]                      best_idx_reg, best_idx_next;
    logic [7:0]                         best_id_reg, best_id_next;
    logic                               free_found_reg, free_found_next;
    logic [7:0]                         free_lab_reg, free_lab_next;
    logic [CW-1:0]                      wr_reg, wr_next;
    logic                               m_valid_reg, m_valid_next;
    bct_pkg::bct_out_t                  m_data_reg, m_data_next;

    // memory ports
    logic                               ram_we;
    logic [IW-1:0]                      ram_waddr, ram_raddr;
    bct_pkg::bct_entry_t                ram_wdata, ram_rdata;

    // distance pipeline
    bct_pkg::bct_tag_t                  dist_in_tag, dist_tag;
    logic [bct_pkg::DIST_W-1:0]         dist_val;
    logic                               dist_busy;

    logic                               s_fire;
    logic [LW-1:0]                      lab_idx;

    bct_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_TRACKS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // the read data of a scan slot meets the blob in the distance pipeline
    always_comb begin
        dist_in_tag     = p1_reg;
        dist_in_tag.vld = p1_reg.vld && state_reg == bct_pkg::ST_SCAN;
        dist_in_tag.id  = ram_rdata.id;
    end

    bct_dist u_dist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_tag  (dist_in_tag),
        .bx      (blob_reg.blob_x),
        .by      (blob_reg.blob_y),
        .tx      (ram_rdata.pos_x),
        .ty      (ram_rdata.pos_y),
        .out_tag (dist_tag),
        .sq_dist (dist_val),
        .busy    (dist_busy)
    );

    assign s_ready = (state_reg == bct_pkg::ST_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign lab_idx = LW'(iss_reg) + LW'(1);

    always_comb begin
        state_next      = state_reg;
        radius_next     = radius_reg;
        thresh_next     = thresh_reg;
        cnt_next        = cnt_reg;
        seen_next       = seen_reg;
        used_next       = used_reg;
        blob_next       = blob_reg;
        empty_next      = empty_reg;
        iss_next        = iss_reg;
        iss_done_next   = iss_done_reg;
        p1_next         = '0;
        found_next      = found_reg;
        best_d_next     = best_d_reg;
        best_idx_next   = best_idx_reg;
        best_id_next    = best_id_reg;
        free_found_next = free_found_reg;
        free_lab_next   = free_lab_reg;
        wr_next         = wr_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = '0;
        ram_raddr       = IW'(iss_reg);

        // the user writes this register only while idle; the block does not enforce it
        if (cfg_we) begin
            radius_next = cfg_wdata;
        end

        case (state_reg)
            bct_pkg::ST_IDLE: begin
                if (s_fire) begin
                    blob_next  = s_data;
                    empty_next = s_data.first_in_frame && s_data.last_in_frame
                                 && s_data.blob_x == '0 && s_data.blob_y == '0;
                    if (s_data.first_in_frame) begin
                        seen_next = '0;
                    end
                    state_next = empty_next ? bct_pkg::ST_FIN : bct_pkg::ST_THR;
                end
            end
            bct_pkg::ST_THR: begin
                thresh_next     = radius_reg * radius_reg;
                iss_next        = '0;
                iss_done_next   = 1'b0;
                found_next      = 1'b0;
                free_found_next = 1'b0;
                state_next      = bct_pkg::ST_SCAN;
            end
            bct_pkg::ST_SCAN: begin
                // issue one slot read per cycle, lowest free label searched alongside
                if (!iss_done_reg) begin
                    if (iss_reg < cnt_reg) begin
                        p1_next.vld = 1'b1;
                        p1_next.idx = 8'(iss_reg);
                    end
                    if (!free_found_reg && iss_reg < CW'(MAX_TRACKS)
                        && !used_reg[lab_idx]) begin
                        free_found_next = 1'b1;
                        free_lab_next   = 8'(iss_reg) + 8'd1;
                    end
                    if (iss_reg == cnt_reg) begin
                        iss_done_next = 1'b1;
                    end else begin
                        iss_next = iss_reg + CW'(1);
                    end
                end
                // strict less keeps the earlier track on a tie
                if (dist_tag.vld && dist_val < {1'b0, thresh_reg}
                    && (!found_reg || dist_val < best_d_reg)) begin
                    found_next    = 1'b1;
                    best_d_next   = dist_val;
                    best_idx_next = IW'(dist_tag.idx);
                    best_id_next  = dist_tag.id;
                end
                if (iss_done_reg && !p1_reg.vld && !dist_busy) begin
                    state_next = bct_pkg::ST_FIN;
                end
            end
            bct_pkg::ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '0;
                    ram_wdata.pos_x = blob_reg.blob_x;
                    ram_wdata.pos_y = blob_reg.blob_y;
                    if (empty_reg) begin
                        // empty frame: nothing stored
                    end else if (found_reg) begin
                        ram_we                = 1'b1;
                        ram_waddr             = best_idx_reg;
                        ram_wdata.id          = best_id_reg;
                        seen_next[best_idx_reg] = 1'b1;
                        m_data_next.track_label = best_id_reg;
                    end else if (cnt_reg < CW'(MAX_TRACKS)) begin
                        ram_we                  = 1'b1;
                        ram_waddr               = IW'(cnt_reg);
                        ram_wdata.id            = free_lab_reg;
                        seen_next[IW'(cnt_reg)] = 1'b1;
                        used_next[LW'(free_lab_reg)] = 1'b1;
                        cnt_next                = cnt_reg + CW'(1);
                        m_data_next.track_label = free_lab_reg;
                        m_data_next.new_track   = 1'b1;
                    end else begin
                        m_data_next.table_full  = 1'b1;
                    end
                    iss_next      = '0;
                    iss_done_next = 1'b0;
                    wr_next       = '0;
                    if (blob_reg.last_in_frame && !empty_reg) begin
                        state_next = bct_pkg::ST_CLEAN;
                    end else begin
                        state_next = bct_pkg::ST_IDLE;
                    end
                end
            end
            bct_pkg::ST_CLEAN: begin
                // compaction: read slot, write it back at the next kept place if seen, else free its label
                if (!iss_done_reg) begin
                    if (iss_reg < cnt_reg) begin
                        p1_next.vld = 1'b1;
                        p1_next.idx = 8'(iss_reg);
                        iss_next    = iss_reg + CW'(1);
                    end else begin
                        iss_done_next = 1'b1;
                    end
                end
                if (p1_reg.vld) begin
                    if (seen_reg[IW'(p1_reg.idx)]) begin
                        ram_we                 = 1'b1;
                        ram_waddr              = IW'(wr_reg);
                        ram_wdata              = ram_rdata;
                        seen_next[IW'(wr_reg)] = 1'b1;
                        wr_next                = wr_reg + CW'(1);
                    end else if (ram_rdata.id <= 8'(MAX_TRACKS)) begin
                        used_next[LW'(ram_rdata.id)] = 1'b0;
                    end
                end
                if (iss_done_reg && !p1_reg.vld) begin
                    cnt_next   = wr_reg;
                    state_next = bct_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bct_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bct_pkg::ST_IDLE;
            radius_reg  <= bct_pkg::RADIUS_RESET;
            cnt_reg     <= '0;
            seen_reg    <= '0;
            used_reg    <= '0;
            p1_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            radius_reg  <= radius_next;
            cnt_reg     <= cnt_next;
            seen_reg    <= seen_next;
            used_reg    <= used_next;
            p1_reg      <= p1_next;
            m_valid_reg <= m_valid_next;
        end
        thresh_reg     <= thresh_next;
        blob_reg       <= blob_next;
        empty_reg      <= empty_next;
        iss_reg        <= iss_next;
        iss_done_reg   <= iss_done_next;
        found_reg      <= found_next;
        best_d_reg     <= best_d_next;
        best_idx_reg   <= best_idx_next;
        best_id_reg    <= best_id_next;
        free_found_reg <= free_found_next;
        free_lab_reg   <= free_lab_next;
        wr_reg         <= wr_next;
        m_data_reg     <= m_data_next;
    end

`ifndef SYNTH
    // track count never exceeds the table size
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(MAX_TRACKS))
        else $error("track count beyond table size");

    // a new track and a full table never come together
    a_new_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_data_reg.new_track && m_data_reg.table_full))
        else $error("new track and full table both set");

    // a new track always carries a real label
    a_new_label: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.new_track) |-> m_data_reg.track_label != '0)
        else $error("new track with label zero");

    // one request at a time
    a_one_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !s_ready)
        else $error("request taken while busy");
`endif

endmodule
`default_nettype wire
